// ----- hw/rtl/trxneg_pkg.sv -----
// shared types, protocol constants and the opening offer table for the telnet receive negotiator
package trxneg_pkg;

	// telnet command bytes
	localparam logic [7:0] B_IAC  = 8'd255;
	localparam logic [7:0] B_DONT = 8'd254;
	localparam logic [7:0] B_DO   = 8'd253;
	localparam logic [7:0] B_WONT = 8'd252;
	localparam logic [7:0] B_WILL = 8'd251;
	localparam logic [7:0] B_SB   = 8'd250;
	localparam logic [7:0] B_SE   = 8'd240;
	localparam logic [7:0] B_NONE = 8'd0;

	// option codes
	localparam logic [7:0] OP_ECHO     = 8'd1;
	localparam logic [7:0] OP_SGA      = 8'd3;
	localparam logic [7:0] OP_NAWS     = 8'd31;
	localparam logic [7:0] OP_LINEMODE = 8'd34;

	// item commands
	localparam logic [1:0] CMD_BYTE  = 2'd0;
	localparam logic [1:0] CMD_NEW   = 2'd1;
	localparam logic [1:0] CMD_OFFER = 2'd2;

	localparam int OFFER_LEN = 12;
	localparam int IDX_W     = $clog2(OFFER_LEN);
	localparam logic [IDX_W-1:0] REPLY_LAST = IDX_W'(2);
	localparam logic [IDX_W-1:0] OFFER_LAST = IDX_W'(OFFER_LEN - 1);

	typedef enum logic [2:0] {
		PS_NORMAL = 3'd0,
		PS_IAC    = 3'd1,
		PS_VERB   = 3'd2,
		PS_SB     = 3'd3,
		PS_SB_IAC = 3'd4
	} ps_t;

	typedef enum logic [1:0] {
		RUN_NONE  = 2'd0,
		RUN_DATA  = 2'd1,
		RUN_REPLY = 2'd2,
		RUN_OFFER = 2'd3
	} run_kind_t;

	// one burst of output words caused by one item
	typedef struct packed {
		run_kind_t  kind;
		logic [7:0] verb;   // reply verb
		logic [7:0] arg;    // data byte or option code
	} run_t;

	typedef struct packed {
		logic echo;
		logic sga;
		logic naws;
		logic lm_refused;
	} flags_t;

	// fixed opening: will echo, will sga, dont linemode, do naws
	function automatic logic [7:0] offer_byte(input logic [IDX_W-1:0] idx);
		logic [7:0] b;
		unique case (idx)
			4'd0, 4'd3, 4'd6, 4'd9: b = B_IAC;
			4'd1, 4'd4:             b = B_WILL;
			4'd2:                   b = OP_ECHO;
			4'd5:                   b = OP_SGA;
			4'd7:                   b = B_DONT;
			4'd8:                   b = OP_LINEMODE;
			4'd10:                  b = B_DO;
			4'd11:                  b = OP_NAWS;
			default:                b = B_IAC;
		endcase
		return b;
	endfunction

endpackage

// ----- hw/rtl/trxneg_parser.sv -----
// iac parser state machine, option flags and reply decision
module trxneg_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [1:0]          command,
	input  logic [7:0]          data_byte,
	output trxneg_pkg::run_t    run
);
	import trxneg_pkg::*;

	ps_t        state_q, state_d;
	logic [7:0] held_verb_q, held_verb_d;
	flags_t     flags_q, flags_d, flags_ans;
	logic [7:0] rv;

	// option answer for the held verb
	always_comb begin
		rv        = B_NONE;
		flags_ans = flags_q;
		case (held_verb_q)
			B_DO: begin
				if (data_byte == OP_ECHO) begin
					if (!flags_q.echo) begin
						flags_ans.echo = 1'b1;
						rv = B_WILL;
					end
				end else if (data_byte == OP_SGA) begin
					if (!flags_q.sga) begin
						flags_ans.sga = 1'b1;
						rv = B_WILL;
					end
				end else begin
					rv = B_WONT;
				end
			end
			B_DONT: begin
				if (data_byte == OP_ECHO && flags_q.echo) begin
					flags_ans.echo = 1'b0;
					rv = B_WONT;
				end else if (data_byte == OP_SGA && flags_q.sga) begin
					flags_ans.sga = 1'b0;
					rv = B_WONT;
				end
			end
			B_WILL: begin
				if (data_byte == OP_NAWS) begin
					if (!flags_q.naws) begin
						flags_ans.naws = 1'b1;
						rv = B_DO;
					end
				end else if (!(data_byte == OP_LINEMODE && flags_q.lm_refused)) begin
					if (data_byte == OP_LINEMODE) begin
						flags_ans.lm_refused = 1'b1;
					end
					rv = B_DONT;
				end
			end
			B_WONT: begin
				if (data_byte == OP_NAWS && flags_q.naws) begin
					flags_ans.naws = 1'b0;
					rv = B_DONT;
				end
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d     = state_q;
		held_verb_d = held_verb_q;
		flags_d     = flags_q;
		unique case (command)
			CMD_BYTE: begin
				unique case (state_q)
					PS_NORMAL: if (data_byte == B_IAC) state_d = PS_IAC;
					PS_IAC: begin
						if (data_byte == B_DO || data_byte == B_DONT ||
						    data_byte == B_WILL || data_byte == B_WONT) begin
							held_verb_d = data_byte;
							state_d     = PS_VERB;
						end else if (data_byte == B_SB) begin
							state_d = PS_SB;
						end else begin
							state_d = PS_NORMAL;
						end
					end
					PS_VERB: begin
						flags_d = flags_ans;
						state_d = PS_NORMAL;
					end
					PS_SB:     state_d = (data_byte == B_IAC) ? PS_SB_IAC : PS_SB;
					PS_SB_IAC: state_d = (data_byte == B_SE) ? PS_NORMAL : PS_SB;
					default:   state_d = PS_NORMAL;
				endcase
			end
			CMD_NEW: begin
				state_d     = PS_NORMAL;
				held_verb_d = '0;
				flags_d     = '0;
			end
			CMD_OFFER: flags_d = '1;
			default: ;
		endcase
	end

	// run descriptor
	always_comb begin
		run.kind = RUN_NONE;
		run.verb = rv;
		run.arg  = data_byte;
		unique case (command)
			CMD_BYTE: begin
				unique case (state_q)
					PS_NORMAL: begin
						if (data_byte != B_IAC && data_byte != 8'd0) run.kind = RUN_DATA;
					end
					PS_IAC: begin
						if (data_byte == B_IAC) run.kind = RUN_DATA;
					end
					PS_VERB: begin
						if (rv != B_NONE) run.kind = RUN_REPLY;
					end
					default: ;
				endcase
			end
			CMD_OFFER: run.kind = RUN_OFFER;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= PS_NORMAL;
			held_verb_q <= '0;
			flags_q     <= '0;
		end else if (fire) begin
			state_q     <= state_d;
			held_verb_q <= held_verb_d;
			flags_q     <= flags_d;
		end
	end

endmodule

// ----- hw/rtl/trxneg_emitter.sv -----
// result register that plays out one run of words and gates input acceptance
module trxneg_emitter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  trxneg_pkg::run_t    run,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [7:0]          out_byte,
	output logic                to_peer,
	output logic                last
);
	import trxneg_pkg::*;

	run_t             run_q;
	logic             vld_q;
	logic [IDX_W-1:0] idx_q;
	logic             load, pop;

	always_comb begin
		case (run_q.kind)
			RUN_REPLY: last = (idx_q == REPLY_LAST);
			RUN_OFFER: last = (idx_q == OFFER_LAST);
			default:   last = 1'b1;
		endcase
	end

	always_comb begin
		case (run_q.kind)
			RUN_REPLY: begin
				if (idx_q == '0)
					out_byte = B_IAC;
				else if (idx_q == REPLY_LAST)
					out_byte = run_q.arg;
				else
					out_byte = run_q.verb;
			end
			RUN_OFFER: out_byte = offer_byte(idx_q);
			default:   out_byte = run_q.arg;
		endcase
	end

	assign to_peer      = (run_q.kind != RUN_DATA);
	assign result_valid = vld_q;
	assign pop          = vld_q && result_ready;
	assign item_ready   = !vld_q || (result_ready && last);
	assign load         = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			vld_q <= (run.kind != RUN_NONE);
			idx_q <= '0;
		end else if (pop) begin
			if (last) begin
				vld_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (load) begin
			run_q <= run;
		end
	end

endmodule

// ----- hw/rtl/telnet_receive_option_negotiator_top.sv -----
// top level of the telnet receive side option negotiator
//
//  channel | signals                          | word
//  --------+----------------------------------+------------------------------
//  item    | item_valid, item_ready           | command, data_byte
//  result  | result_valid, result_ready       | out_byte, to_peer, last
//
// an item is parsed in the cycle it is accepted; its words come out of the
// result register from the next cycle on, one per cycle while result_ready is high
// data bytes and silent items pass at one item per cycle while result_ready is high;
// a reply stalls the next item for its 3 words, the offer for 12, set by the word counter
// the next item is taken in the cycle the last word of the current run leaves
// arst_n clears parser state, option flags and the result register at once
// a stalled result side holds the current word and, with it, the item side
module telnet_receive_option_negotiator_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [1:0] command,
	input  logic [7:0] data_byte,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] out_byte,
	output logic       to_peer,
	output logic       last
);
	import trxneg_pkg::*;

	run_t run;      // words caused by the item on the port
	logic fire;     // item accepted this cycle

	assign fire = item_valid && item_ready;

	// parser updates its state only on an accepted item
	trxneg_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.command   (command),
		.data_byte (data_byte),
		.run       (run)
	);

	// result register and run counter
	trxneg_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.run          (run),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_byte     (out_byte),
		.to_peer      (to_peer),
		.last         (last)
	);

endmodule
